[rtl/gda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

    // Field widths of the two channels.
    localparam int CMD_W  = 2;
    localparam int AMT_W  = 12;
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;

    // The working counter holds a year (14 bits) or seven times the largest count.
    localparam int CNT_W  = 15;

    localparam int DEF_MAX_AMOUNT = 4095;
    localparam int DEF_MAX_YEAR   = 9999;

    // Calendar constants.
    localparam int YEAR_CYCLE      = 400;
    localparam int CENTURY         = 100;
    localparam int MONTHS_PER_YEAR = 12;
    localparam int LEAP_FEB        = 29;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_DAYS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WEEKS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MONTHS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_YEAR   = 2'd3;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MOD400,
        OP_SETUP,
        OP_DAYSTEP,
        OP_MONSTEP,
        OP_YEARINC,
        OP_CLAMP,
        OP_FINAL
    } t_op;

    // Sequencer to datapath.
    typedef struct packed {
        t_op  op;
        logic in_ready;
        logic out_valid;
    } t_ctrl;

    // Datapath and channel status back to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic ge400;
        logic invalid;
        logic is_months;
        logic is_year;
        logic day_more;
        logic ge12;
    } t_flags;

    // Length of a month; zero for a month code outside the calendar.
    function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] mon,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        if (mon == 4'd0 || mon > 4'(MONTHS_PER_YEAR)) begin
            len = '0;
        end else if (mon == 4'd2) begin
            len = leap ? 5'(LEAP_FEB) : MONTH_LEN[1];
        end else begin
            len = MONTH_LEN[4'(mon - 4'd1)];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/gda_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel: a command, a count and a starting date.
interface gda_in_if;
    logic                        valid;
    logic                        ready;
    logic [gda_pkg::CMD_W-1:0]   cmd;
    logic [gda_pkg::AMT_W-1:0]   amount;
    logic [gda_pkg::DAY_W-1:0]   start_day;
    logic [gda_pkg::MON_W-1:0]   start_month;
    logic [gda_pkg::YEAR_W-1:0]  start_year;

    modport source (output valid, cmd, amount, start_day, start_month, start_year,
                    input ready);
    modport sink   (input valid, cmd, amount, start_day, start_month, start_year,
                    output ready);
endinterface

// Response channel: the moved date and the error flag.
interface gda_out_if;
    logic                        valid;
    logic                        ready;
    logic [gda_pkg::DAY_W-1:0]   out_day;
    logic [gda_pkg::MON_W-1:0]   out_month;
    logic [gda_pkg::YEAR_W-1:0]  out_year;
    logic                        bad_date;

    modport source (output valid, out_day, out_month, out_year, bad_date,
                    input ready);
    modport sink   (input valid, out_day, out_month, out_year, bad_date,
                    output ready);
endinterface

`default_nettype wire

[rtl/gda_useq.sv]
`timescale 1ns / 1ps
`default_nettype none

module gda_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gda_pkg::t_flags i_flags,
    output gda_pkg::t_ctrl       o_ctrl
);
    import gda_pkg::*;

    typedef enum logic [3:0] {
        S_WAIT,
        S_MOD,
        S_CHECK,
        S_DISP_M,
        S_DISP_Y,
        S_DAY,
        S_MONTH,
        S_YEAR,
        S_CLAMP,
        S_FIN,
        S_OUT
    } t_step;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_IDLE,
        C_GE400,
        C_INVALID,
        C_MONTHS,
        C_YEAR,
        C_DAY_MORE,
        C_GE12,
        C_OUT_HOLD
    } t_cond;

    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_uword;

    function automatic t_uword mk(input t_op op, input logic rdy, input logic vld,
                                  input t_cond cond, input t_step tt, input t_step tf);
        t_uword w;
        w.ctrl.op        = op;
        w.ctrl.in_ready  = rdy;
        w.ctrl.out_valid = vld;
        w.cond           = cond;
        w.tgt_t          = tt;
        w.tgt_f          = tf;
        return w;
    endfunction

    // Program store: one control word per step, a jump target for each outcome.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            S_WAIT:   w = mk(OP_LOAD,    1'b1, 1'b0, C_IN_IDLE,  S_WAIT,  S_MOD);
            S_MOD:    w = mk(OP_MOD400,  1'b0, 1'b0, C_GE400,    S_MOD,   S_CHECK);
            S_CHECK:  w = mk(OP_SETUP,   1'b0, 1'b0, C_INVALID,  S_OUT,   S_DISP_M);
            S_DISP_M: w = mk(OP_NOP,     1'b0, 1'b0, C_MONTHS,   S_MONTH, S_DISP_Y);
            S_DISP_Y: w = mk(OP_NOP,     1'b0, 1'b0, C_YEAR,     S_YEAR,  S_DAY);
            S_DAY:    w = mk(OP_DAYSTEP, 1'b0, 1'b0, C_DAY_MORE, S_DAY,   S_FIN);
            S_MONTH:  w = mk(OP_MONSTEP, 1'b0, 1'b0, C_GE12,     S_MONTH, S_CLAMP);
            S_YEAR:   w = mk(OP_YEARINC, 1'b0, 1'b0, C_ALWAYS,   S_CLAMP, S_CLAMP);
            S_CLAMP:  w = mk(OP_CLAMP,   1'b0, 1'b0, C_ALWAYS,   S_FIN,   S_FIN);
            S_FIN:    w = mk(OP_FINAL,   1'b0, 1'b0, C_ALWAYS,   S_OUT,   S_OUT);
            S_OUT:    w = mk(OP_NOP,     1'b0, 1'b1, C_OUT_HOLD, S_OUT,   S_WAIT);
            default:  w = mk(OP_NOP,     1'b0, 1'b0, C_ALWAYS,   S_WAIT,  S_WAIT);
        endcase
        return w;
    endfunction

    t_step  r_pc;
    t_step  n_pc;
    t_uword w_uw;
    logic   w_take;

    assign w_uw   = ucode(r_pc);
    assign o_ctrl = w_uw.ctrl;

    always_comb begin
        unique case (w_uw.cond)
            C_ALWAYS:   w_take = 1'b1;
            C_IN_IDLE:  w_take = !i_flags.in_valid;
            C_GE400:    w_take = i_flags.ge400;
            C_INVALID:  w_take = i_flags.invalid;
            C_MONTHS:   w_take = i_flags.is_months;
            C_YEAR:     w_take = i_flags.is_year;
            C_DAY_MORE: w_take = i_flags.day_more;
            C_GE12:     w_take = i_flags.ge12;
            C_OUT_HOLD: w_take = !i_flags.out_ready;
            default:    w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uw.tgt_t : w_uw.tgt_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

[rtl/gregorian_date_adder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Port    Dir  Contents
// request   i_req   in   cmd, amount, start_day, start_month, start_year
// response  o_rsp   out  out_day, out_month, out_year, bad_date
//
// One item is in flight at a time; the next request is taken once the response is gone.
// An item first reduces the year modulo 400 by repeated subtraction and checks the date,
// then takes one step per day added (n up to 7 x 4095 for weeks), one step per whole
// year crossed by months, a single year step for one year, and none for a rejected date;
// a wait step and the response follow.
// Reset is synchronous and only returns the step counter; the response holds while stalled.

module gregorian_date_adder #(
    parameter int MAX_AMOUNT = gda_pkg::DEF_MAX_AMOUNT,
    parameter int MAX_YEAR   = gda_pkg::DEF_MAX_YEAR
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gda_in_if.sink     i_req,
    gda_out_if.source  o_rsp
);
    import gda_pkg::*;

    // The working year can run past the limit by the years that one item can cross.
    localparam int YW_NEED = $clog2(MAX_YEAR + 512);
    localparam int YW      = (YW_NEED > YEAR_W) ? YW_NEED : YEAR_W;

    localparam logic [YW-1:0] MAXY = YW'(MAX_YEAR);
    localparam logic [16:0]   MAXA = 17'(MAX_AMOUNT);

    t_ctrl  w_ctrl;
    t_flags w_flags;

    // Copy of the request, returned unchanged when the date is rejected.
    logic [CMD_W-1:0]  r_cmd,  n_cmd;
    logic [AMT_W-1:0]  r_amt,  n_amt;
    logic [DAY_W-1:0]  r_d0,   n_d0;
    logic [MON_W-1:0]  r_m0,   n_m0;
    logic [YEAR_W-1:0] r_y0,   n_y0;

    // Working date, count and the year's position in the 400-year cycle.
    logic [DAY_W-1:0]  r_d,    n_d;
    logic [MON_W-1:0]  r_m,    n_m;
    logic [YW-1:0]     r_y,    n_y;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [8:0]        r_r400, n_r400;
    logic              r_bad,  n_bad;

    logic              w_leap;
    logic [DAY_W-1:0]  w_dim;
    logic [8:0]        w_r400_inc;
    logic              w_y_over;
    logic              w_ge400;
    logic              w_ge12;
    logic              w_invalid;
    logic              w_day_more;
    logic [AMT_W-1:0]  w_amt_sat;

    gda_useq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // The year modulo 4 equals the cycle position modulo 4, so the cycle position
    // alone decides the leap rule.
    assign w_leap = (r_r400[1:0] == 2'd0) && (r_r400 != 9'(CENTURY)) &&
                    (r_r400 != 9'(2 * CENTURY)) && (r_r400 != 9'(3 * CENTURY));
    assign w_dim      = days_in(r_m, w_leap);
    assign w_r400_inc = (r_r400 == 9'(YEAR_CYCLE - 1)) ? 9'd0 : r_r400 + 9'd1;
    assign w_y_over   = r_y > MAXY;
    assign w_ge400    = r_cnt >= CNT_W'(YEAR_CYCLE);
    assign w_ge12     = r_cnt >= CNT_W'(MONTHS_PER_YEAR);
    assign w_invalid  = (r_m == 4'd0) || (r_m > 4'(MONTHS_PER_YEAR)) || (r_d == 5'd0) ||
                        (r_d > w_dim) || w_y_over;
    // The day loop may stop early once the year has overflowed: it only grows.
    assign w_day_more = (r_cnt != '0) && !w_y_over;
    assign w_amt_sat  = ({5'd0, i_req.amount} > MAXA) ? AMT_W'(MAX_AMOUNT) : i_req.amount;

    assign w_flags.in_valid  = i_req.valid;
    assign w_flags.out_ready = o_rsp.ready;
    assign w_flags.ge400     = w_ge400;
    assign w_flags.invalid   = w_invalid;
    assign w_flags.is_months = r_cmd == CMD_MONTHS;
    assign w_flags.is_year   = r_cmd == CMD_YEAR;
    assign w_flags.day_more  = w_day_more;
    assign w_flags.ge12      = w_ge12;

    always_comb begin
        n_cmd  = r_cmd;
        n_amt  = r_amt;
        n_d0   = r_d0;
        n_m0   = r_m0;
        n_y0   = r_y0;
        n_d    = r_d;
        n_m    = r_m;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_r400 = r_r400;
        n_bad  = r_bad;
        unique case (w_ctrl.op)
            OP_LOAD: begin
                if (i_req.valid) begin
                    n_cmd = i_req.cmd;
                    n_amt = w_amt_sat;
                    n_d0  = i_req.start_day;
                    n_m0  = i_req.start_month;
                    n_y0  = i_req.start_year;
                    n_d   = i_req.start_day;
                    n_m   = i_req.start_month;
                    n_y   = YW'(i_req.start_year);
                    n_cnt = CNT_W'(i_req.start_year);
                    n_bad = 1'b0;
                end
            end
            OP_MOD400: begin
                if (w_ge400) begin
                    n_cnt = r_cnt - CNT_W'(YEAR_CYCLE);
                end else begin
                    n_r400 = r_cnt[8:0];
                end
            end
            OP_SETUP: begin
                n_bad = w_invalid;
                case (r_cmd)
                    CMD_DAYS:   n_cnt = CNT_W'(r_amt);
                    CMD_WEEKS:  n_cnt = (CNT_W'(r_amt) << 3) - CNT_W'(r_amt);
                    CMD_MONTHS: n_cnt = CNT_W'(r_m) - CNT_W'(1) + CNT_W'(r_amt);
                    default:    n_cnt = '0;
                endcase
            end
            OP_DAYSTEP: begin
                if (w_day_more) begin
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_d == w_dim) begin
                        n_d = 5'd1;
                        if (r_m == 4'(MONTHS_PER_YEAR)) begin
                            n_m    = 4'd1;
                            n_y    = r_y + YW'(1);
                            n_r400 = w_r400_inc;
                        end else begin
                            n_m = r_m + 4'd1;
                        end
                    end else begin
                        n_d = r_d + 5'd1;
                    end
                end
            end
            OP_MONSTEP: begin
                if (w_ge12) begin
                    n_cnt  = r_cnt - CNT_W'(MONTHS_PER_YEAR);
                    n_y    = r_y + YW'(1);
                    n_r400 = w_r400_inc;
                end else begin
                    n_m = r_cnt[MON_W-1:0] + 4'd1;
                end
            end
            OP_YEARINC: begin
                n_y    = r_y + YW'(1);
                n_r400 = w_r400_inc;
            end
            OP_CLAMP: begin
                if (r_d > w_dim) begin
                    n_d = w_dim;
                end
            end
            OP_FINAL: begin
                n_bad = w_y_over;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_amt  <= n_amt;
        r_d0   <= n_d0;
        r_m0   <= n_m0;
        r_y0   <= n_y0;
        r_d    <= n_d;
        r_m    <= n_m;
        r_y    <= n_y;
        r_cnt  <= n_cnt;
        r_r400 <= n_r400;
        r_bad  <= n_bad;
    end

    assign i_req.ready     = w_ctrl.in_ready;
    assign o_rsp.valid     = w_ctrl.out_valid;
    assign o_rsp.out_day   = r_bad ? r_d0 : r_d;
    assign o_rsp.out_month = r_bad ? r_m0 : r_m;
    assign o_rsp.out_year  = r_bad ? r_y0 : r_y[YEAR_W-1:0];
    assign o_rsp.bad_date  = r_bad;

    // Only one item may be in flight.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request taken while a response is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (!i_req.ready && !o_rsp.valid))
        else $error("sequencer did not start work on the accepted item");

    a_good_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.bad_date) |->
            (o_rsp.out_month != 4'd0 && o_rsp.out_month <= 4'(MONTHS_PER_YEAR) &&
             o_rsp.out_day != 5'd0 && o_rsp.out_day <= w_dim))
        else $error("accepted result is not a calendar date");

    a_year_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.bad_date) |-> !w_y_over)
        else $error("result year beyond the limit without the error flag");

endmodule

`default_nettype wire
